@@ hw/rtl/tbs_pkg.sv @@
// tbs_pkg: widths, limits and reset tolerance for the triangle barycentric solver.
// No dependencies; imported by the solver and its checker.
`default_nettype none
package tbs_pkg;
    localparam int CoordW  = 32;
    localparam int DiffW   = CoordW + 1;
    localparam int ProdW   = 2 * DiffW;
    localparam int NumerW  = ProdW + 1;
    localparam int DetW    = NumerW + 2;
    localparam int FracW   = 24;
    localparam int DivW    = NumerW + FracW + 2;
    localparam int QW      = 32;
    localparam int RemW    = DetW + QW;
    localparam int TolW    = 25;
    localparam int WeightW = 32;
    localparam int NumW    = 3;
    localparam logic [QW-1:0] PosLimit = 32'h7FFF_FFFF;
    localparam logic [QW-1:0] NegLimit = 32'h8000_0000;
    localparam logic [TolW-1:0] TolReset = 25'd16;

    typedef logic signed [DiffW-1:0]  diff_t;
    typedef logic signed [ProdW-1:0]  prod_t;
    typedef logic signed [NumerW-1:0] numer_t;
    typedef logic signed [DetW-1:0]   det_t;
    typedef logic [RemW-1:0]          rem_t;
    typedef logic [QW-1:0]            quot_t;
endpackage
`default_nettype wire

@@ hw/rtl/triangle_barycentric_solve.sv @@
// Triangle barycentric solver: cofactor numerators, determinant, pipelined division.
// Depends on tbs_pkg.
// Pipeline stages from input beat to result beat: 7 front stages,
// 32 restoring-division stages (one quotient bit each), 2 output stages.
// Throughput: one beat per cycle; the whole pipeline holds while a result is stalled.
// Reset clears all valid bits and sets the tolerance register tol_reg to 16.
`default_nettype none
module triangle_barycentric_solve
    import tbs_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [TolW-1:0]          cfg_wr_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic signed [CoordW-1:0] point_x,
    input  wire logic signed [CoordW-1:0] point_y,
    input  wire logic signed [CoordW-1:0] vertex0_x,
    input  wire logic signed [CoordW-1:0] vertex0_y,
    input  wire logic signed [CoordW-1:0] vertex1_x,
    input  wire logic signed [CoordW-1:0] vertex1_y,
    input  wire logic signed [CoordW-1:0] vertex2_x,
    input  wire logic signed [CoordW-1:0] vertex2_y,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          inside_res,
    output logic                          degenerate,
    output logic signed [WeightW-1:0]     weight0,
    output logic signed [WeightW-1:0]     weight1,
    output logic signed [WeightW-1:0]     weight2
);
    localparam int NStage = 7 + QW + 2;

    logic            en;
    logic [TolW-1:0] tol_reg;
    logic [NStage-1:0] vld_reg;

    diff_t  dx_reg [NumW], dy_reg [NumW];
    prod_t  pr_reg [2*NumW];
    numer_t n3_reg [NumW], n4_reg [NumW];
    det_t   det4_reg;
    logic [NumerW-1:0] an_reg [NumW];
    logic [DetW-1:0]   ad5_reg, ad6_reg;
    logic [NumW-1:0]   neg5_reg, neg6_reg;
    logic              deg5_reg, deg6_reg;
    logic [DivW-1:0]   num_reg [NumW];

    rem_t             rem_reg [QW+1][NumW];
    quot_t            q_reg   [QW+1][NumW];
    logic [NumW-1:0]  sat_reg [QW+1];
    logic [NumW-1:0]  neg_reg [QW+1];
    logic [DetW-1:0]  dsr_reg [QW+1];
    logic             deg_reg [QW+1];

    logic signed [WeightW-1:0] wf_reg [NumW];
    logic                      degf_reg;

    assign en       = !(vld_reg[NStage-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TolReset;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                tol_reg <= cfg_wr_data;
            if (en)
                vld_reg <= {vld_reg[NStage-2:0], in_valid};
        end
    end

    // front stages: differences, products, numerators, determinant, magnitudes, dividends, saturation check
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg[0] <= DiffW'(vertex0_x) - DiffW'(point_x);
            dx_reg[1] <= DiffW'(vertex1_x) - DiffW'(point_x);
            dx_reg[2] <= DiffW'(vertex2_x) - DiffW'(point_x);
            dy_reg[0] <= DiffW'(vertex0_y) - DiffW'(point_y);
            dy_reg[1] <= DiffW'(vertex1_y) - DiffW'(point_y);
            dy_reg[2] <= DiffW'(vertex2_y) - DiffW'(point_y);

            pr_reg[0] <= dx_reg[1] * dy_reg[2];
            pr_reg[1] <= dx_reg[2] * dy_reg[1];
            pr_reg[2] <= dx_reg[2] * dy_reg[0];
            pr_reg[3] <= dx_reg[0] * dy_reg[2];
            pr_reg[4] <= dx_reg[0] * dy_reg[1];
            pr_reg[5] <= dx_reg[1] * dy_reg[0];

            for (int i = 0; i < NumW; i++)
            begin
                n3_reg[i] <= NumerW'(pr_reg[2*i]) - NumerW'(pr_reg[2*i+1]);
                n4_reg[i] <= n3_reg[i];
                an_reg[i] <= n4_reg[i][NumerW-1] ? NumerW'(-n4_reg[i]) : NumerW'(n4_reg[i]);
                neg5_reg[i] <= n4_reg[i][NumerW-1] ^ det4_reg[DetW-1];
                num_reg[i] <= {2'b00, an_reg[i], {FracW{1'b0}}} + DivW'(ad5_reg >> 1);
            end
            det4_reg <= DetW'(n3_reg[0]) + DetW'(n3_reg[1]) + DetW'(n3_reg[2]);
            ad5_reg  <= det4_reg[DetW-1] ? DetW'(-det4_reg) : DetW'(det4_reg);
            deg5_reg <= (det4_reg == '0);
            ad6_reg  <= ad5_reg;
            neg6_reg <= neg5_reg;
            deg6_reg <= deg5_reg;

            for (int i = 0; i < NumW; i++)
            begin
                sat_reg[0][i] <= (RemW'(num_reg[i]) >= (RemW'(ad6_reg) << QW));
                rem_reg[0][i] <= RemW'(num_reg[i]);
                q_reg[0][i]   <= '0;
            end
            neg_reg[0] <= neg6_reg;
            dsr_reg[0] <= ad6_reg;
            deg_reg[0] <= deg6_reg;
        end
    end

    // restoring division, quotient bit QW-1-k in stage k
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        localparam int Sh = QW - 1 - k;
        rem_t dsh;
        assign dsh = RemW'(dsr_reg[k]) << Sh;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < NumW; i++)
                begin
                    if (rem_reg[k][i] >= dsh)
                    begin
                        rem_reg[k+1][i] <= rem_reg[k][i] - dsh;
                        q_reg[k+1][i]   <= q_reg[k][i] | (quot_t'(1) << Sh);
                    end
                    else
                    begin
                        rem_reg[k+1][i] <= rem_reg[k][i];
                        q_reg[k+1][i]   <= q_reg[k][i];
                    end
                end
                sat_reg[k+1] <= sat_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                dsr_reg[k+1] <= dsr_reg[k];
                deg_reg[k+1] <= deg_reg[k];
            end
        end
    end

    // saturation, sign, degenerate, then inside test
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NumW; i++)
            begin
                if (deg_reg[QW])
                    wf_reg[i] <= '0;
                else if (neg_reg[QW][i])
                    wf_reg[i] <= (sat_reg[QW][i] || q_reg[QW][i] > NegLimit)
                                 ? NegLimit : -q_reg[QW][i];
                else
                    wf_reg[i] <= (sat_reg[QW][i] || q_reg[QW][i] > PosLimit)
                                 ? PosLimit : q_reg[QW][i];
            end
            degf_reg   <= deg_reg[QW];
            degenerate <= degf_reg;
            weight0    <= wf_reg[0];
            weight1    <= wf_reg[1];
            weight2    <= wf_reg[2];
            inside_res <= !degf_reg
                && ((WeightW+2)'(wf_reg[0]) >= -$signed({9'b0, tol_reg}))
                && ((WeightW+2)'(wf_reg[1]) >= -$signed({9'b0, tol_reg}))
                && ((WeightW+2)'(wf_reg[2]) >= -$signed({9'b0, tol_reg}));
        end
    end

    assign out_valid = vld_reg[NStage-1];
endmodule
`default_nettype wire

@@ hw/rtl/tbs_chk.sv @@
// tbs_chk: port-level assertions for triangle_barycentric_solve, with its bind.
// Depends on tbs_pkg.
`default_nettype none
module tbs_chk
    import tbs_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_stall,
    input wire logic                     out_valid,
    input wire logic                     out_stall,
    input wire logic                     inside_res,
    input wire logic                     degenerate,
    input wire logic signed [WeightW-1:0] weight0,
    input wire logic signed [WeightW-1:0] weight1,
    input wire logic signed [WeightW-1:0] weight2
);
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> weight0 == 0 && weight1 == 0 && weight2 == 0
            && !inside_res)
        else $error("degenerate beat with nonzero weights or inside set");

    a_inside_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inside_res |-> weight0 >= -32'sd33554431
            && weight1 >= -32'sd33554431 && weight2 >= -32'sd33554431)
        else $error("inside beat with weight below tolerance range");

    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(weight0) && $stable(weight1)
            && $stable(weight2) && $stable(inside_res) && $stable(degenerate))
        else $error("stalled result beat changed");
endmodule

bind triangle_barycentric_solve tbs_chk u_tbs_chk (.*);
`default_nettype wire

@@ tb/sv/tb_triangle_barycentric_solve.sv @@
// Self-checking testbench for triangle_barycentric_solve: directed table then random beats.
// Predicts barycentric weights with wide integer math; depends on tbs_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_triangle_barycentric_solve;
    import tbs_pkg::*;

    typedef struct packed {
        logic signed [31:0] px, py, x0, y0, x1, y1, x2, y2;
    } tri_beat_t;

    typedef struct packed {
        logic       in_tri;
        logic       degen;
        logic signed [31:0] w0, w1, w2;
    } weights_t;

    typedef struct {
        tri_beat_t beat;
        logic      has_exp;
        weights_t  exp;
        logic      set_tol;
        logic [TolW-1:0] tol;
    } vec_row_t;

    localparam int LATENCY = 41;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_RANDOM = 950;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [TolW-1:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    tri_beat_t in_beat = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic inside_res, degenerate;
    logic signed [31:0] weight0, weight1, weight2;

    logic [TolW-1:0] tol_model = TolReset;
    weights_t pending_weights[$];
    int mismatches = 0;
    int cycles = 0;
    bit hold_long = 1'b0;

    triangle_barycentric_solve dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .point_x(in_beat.px), .point_y(in_beat.py),
        .vertex0_x(in_beat.x0), .vertex0_y(in_beat.y0),
        .vertex1_x(in_beat.x1), .vertex1_y(in_beat.y1),
        .vertex2_x(in_beat.x2), .vertex2_y(in_beat.y2),
        .out_valid(out_valid), .out_stall(out_stall),
        .inside_res(inside_res), .degenerate(degenerate),
        .weight0(weight0), .weight1(weight1), .weight2(weight2)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("triangle_barycentric_solve test failed");
            $finish;
        end
    end

    function automatic logic signed [31:0] round_weight(logic signed [127:0] num,
                                                        logic signed [127:0] det);
        logic neg;
        logic [127:0] an, ad, q;
        logic [31:0] lim;
        neg = num[127] != det[127];
        an = num[127] ? -num : num;
        ad = det[127] ? -det : det;
        q = ((an << 24) + (ad >> 1)) / ad;
        lim = neg ? NegLimit : PosLimit;
        if (q > {96'd0, lim})
            q = {96'd0, lim};
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic weights_t solve_weights(tri_beat_t b, logic [TolW-1:0] tol);
        logic signed [127:0] dx0, dy0, dx1, dy1, dx2, dy2, n0, n1, n2, det, lim;
        weights_t r;
        dx0 = 128'(b.x0) - 128'(b.px);
        dy0 = 128'(b.y0) - 128'(b.py);
        dx1 = 128'(b.x1) - 128'(b.px);
        dy1 = 128'(b.y1) - 128'(b.py);
        dx2 = 128'(b.x2) - 128'(b.px);
        dy2 = 128'(b.y2) - 128'(b.py);
        n0 = dx1 * dy2 - dx2 * dy1;
        n1 = dx2 * dy0 - dx0 * dy2;
        n2 = dx0 * dy1 - dx1 * dy0;
        det = n0 + n1 + n2;
        r = '0;
        if (det == 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        r.w0 = round_weight(n0, det);
        r.w1 = round_weight(n1, det);
        r.w2 = round_weight(n2, det);
        lim = -$signed({103'd0, tol});
        r.in_tri = (128'(r.w0) >= lim) && (128'(r.w1) >= lim) && (128'(r.w2) >= lim);
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 2047)) - 1024) <<< 16;
            default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)) <<< 4;
        endcase
    endfunction

    function automatic tri_beat_t rand_beat();
        tri_beat_t b;
        b.x0 = rand_coord(); b.y0 = rand_coord();
        b.x1 = rand_coord(); b.y1 = rand_coord();
        b.x2 = rand_coord(); b.y2 = rand_coord();
        case ($urandom_range(0, 9))
            0: begin b.px = rand_coord(); b.py = rand_coord(); end
            1: begin b.x2 = b.x1; b.y2 = b.y1; b.px = b.x0; b.py = b.y0; end
            2: begin b.px = b.x0; b.py = b.y0; end
            default:
            begin
                // point near the centroid, usually inside
                b.px = 32'((64'(b.x0) + 64'(b.x1) + 64'(b.x2)) / 3 +
                           $signed($urandom_range(0, 64)) - 32);
                b.py = 32'((64'(b.y0) + 64'(b.y1) + 64'(b.y2)) / 3 +
                           $signed($urandom_range(0, 64)) - 32);
            end
        endcase
        return b;
    endfunction

    task automatic write_tol(logic [TolW-1:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tol_model = v;
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (pending_weights.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic send_beat(tri_beat_t b, logic has_exp, weights_t exp);
        weights_t pred;
        int gap;
        gap = $urandom_range(0, 13);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_beat <= b;
        in_valid <= 1'b1;
        pred = solve_weights(b, tol_model);
        do @(posedge clk); while (in_stall);
        pending_weights.push_back(has_exp ? exp : pred);
    endtask

    function automatic vec_row_t mk_row(logic [31:0] px, py, x0, y0, x1, y1, x2, y2,
                                        logic has_exp, weights_t exp);
        vec_row_t r;
        r.beat = '{px, py, x0, y0, x1, y1, x2, y2};
        r.has_exp = has_exp;
        r.exp = exp;
        r.set_tol = 1'b0;
        r.tol = '0;
        return r;
    endfunction

    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] MX = 32'h7FFF_FFFF;
    localparam logic [31:0] MN = 32'h8000_0000;
    localparam weights_t DEGEN = '{1'b0, 1'b1, 32'd0, 32'd0, 32'd0};

    // receiver: random stalls, one long hold-off
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_long = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (gap != 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        weights_t got, exp;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{inside_res, degenerate, weight0, weight1, weight2};
            if (pending_weights.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %p", got);
            end
            else
            begin
                exp = pending_weights.pop_front();
                if (got !== exp)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp, got);
                end
            end
        end
    end

    initial
    begin
        vec_row_t rows[$];
        tri_beat_t b;
        rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 1'b1, DEGEN));
        rows.push_back(mk_row(ONE, ONE, 0, 0, ONE, ONE, 32'h0002_0000, 32'h0002_0000,
                              1'b1, DEGEN));
        rows.push_back(mk_row(0, 0, 0, 0, ONE, 0, 0, ONE, 1'b1,
                              '{1'b1, 1'b0, 32'h0100_0000, 32'd0, 32'd0}));
        rows.push_back(mk_row(ONE, 0, 0, 0, ONE, 0, 0, ONE, 1'b1,
                              '{1'b1, 1'b0, 32'd0, 32'h0100_0000, 32'd0}));
        rows.push_back(mk_row(0, ONE, 0, 0, ONE, 0, 0, ONE, 1'b1,
                              '{1'b1, 1'b0, 32'd0, 32'd0, 32'h0100_0000}));
        rows.push_back(mk_row(MX, MX, 0, 0, ONE, 0, 0, ONE, 1'b0, '0));
        rows.push_back(mk_row(MN, MN, 0, 0, ONE, 0, 0, ONE, 1'b0, '0));
        rows.push_back(mk_row(MX, MN, MN, MN, MX, MN, MN, MX, 1'b0, '0));
        rows.push_back(mk_row(MN, MX, MX, MX, MN, MX, MX, MN, 1'b0, '0));
        rows.push_back(mk_row(32'h0000_5555, 32'h0000_5555, 0, 0, ONE, 0, 0, ONE, 1'b0, '0));
        rows.push_back(mk_row(32'hFFFF_FFFF, 32'h0000_8000, 0, 0, ONE, 0, 0, ONE, 1'b0, '0));
        rows.push_back(mk_row(32'hFFFF_FFF8, 32'h0000_8000, 0, 0, ONE, 0, 0, ONE, 1'b0, '0));
        rows.push_back(mk_row(0, 0, MX, MX, MN, MX, MX, MN, 1'b0, '0));
        rows.push_back(mk_row(32'h1234_5678, 32'hEDCB_A987, 1, 2, 3, 5, 7, 11, 1'b0, '0));
        rows.push_back(mk_row(1, 1, 0, 0, 2, 0, 0, 3, 1'b0, '0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_beat(rows[i].beat, rows[i].has_exp, rows[i].exp);
        drain_pipe();
        write_tol(25'h1FF_FFFF);
        send_beat(rows[10].beat, 1'b0, '0);
        send_beat(rows[11].beat, 1'b0, '0);
        drain_pipe();
        write_tol('0);
        send_beat(rows[10].beat, 1'b0, '0);
        send_beat(rows[11].beat, 1'b0, '0);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i % 200 == 199)
            begin
                drain_pipe();
                case ((i / 200) % 4)
                    0: write_tol(25'h100_0000);
                    1: write_tol(25'($urandom_range(0, 4096)));
                    2: write_tol(TolReset);
                    default: write_tol(25'($urandom));
                endcase
            end
            if (i == 300)
                hold_long = 1'b1;
            b = rand_beat();
            if (i > 300 && i < 400)
            begin
                // back to back during the long hold-off
                in_beat <= b;
                in_valid <= 1'b1;
                pending_weights.push_back(solve_weights(b, tol_model));
                do @(posedge clk); while (in_stall);
            end
            else
                send_beat(b, 1'b0, '0);
        end
        drain_pipe();
        if (mismatches == 0)
            $display("triangle_barycentric_solve test passed");
        else
            $display("triangle_barycentric_solve test failed");
        $finish;
    end
endmodule
`default_nettype wire
